// File: hw/rtl/stsm_pkg.sv
// Package for the segment tree block: widths, command codes and the node type.
// Used by every module of the block; depends on nothing.
package stsm_pkg;
  localparam int NUM_ELEMENTS_DEF = 1024;
  localparam int SUM_W = 42;
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODULO = 2'd2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] maxv;
  } node_t;
endpackage

// File: hw/rtl/stsm_mem.sv
// Single-write, single-read node memory with a registered read port.
// Depends on stsm_pkg for the node type.
module stsm_mem #(
  parameter int AW = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  stsm_pkg::node_t      wdata,
  input  logic [AW-1:0]        raddr,
  output stsm_pkg::node_t      rdata
);
  import stsm_pkg::*;

  node_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/stsm_div.sv
// Restoring divider that yields the remainder, one quotient bit per cycle.
// Depends on stsm_pkg for the value width.
module stsm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [stsm_pkg::VAL_W-1:0] dividend,
  input  logic [stsm_pkg::VAL_W-1:0] divisor,
  output logic                      done,
  output logic [stsm_pkg::VAL_W-1:0] remainder
);
  import stsm_pkg::*;

  localparam int CW = $clog2(VAL_W + 1);

  logic [VAL_W:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0] quo_r, quo_nxt;
  logic [VAL_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [VAL_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[VAL_W-1:0], quo_r[VAL_W-1]};
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(VAL_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[VAL_W-1:0];
endmodule

// File: hw/rtl/segment_tree_sum_max_range_modulo.sv
// Top level of the segment tree block: command sequencer around the node memory.
// Depends on stsm_pkg, stsm_mem and stsm_div.
//
// Elements live at the leaves of a bottom-up tree held in one node memory of
// 2*P entries (P is NUM_ELEMENTS rounded up to a power of two), each node holding
// a sum and a maximum. After reset the block clears all 2*P nodes (2048 by
// default), one node per cycle, and holds busy high meanwhile. A command is
// taken when start is high and busy is low. An assign writes the leaf, then
// rebuilds each ancestor by reading its two children and writing the node. A
// sum query reads one node at a time through the single read port; its result
// appears for exactly one cycle with out_valid, and the receiver cannot stall
// it. A range modulo reads each leaf in the range, runs the divider on each
// leaf not below the divisor, then rebuilds the ancestors; it stops after
// reading the root when the root maximum is below the divisor.
module segment_tree_sum_max_range_modulo #(
  parameter int NUM_ELEMENTS = stsm_pkg::NUM_ELEMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [stsm_pkg::CMD_W-1:0] in_command,
  input  logic [stsm_pkg::IDX_W-1:0] in_low_index,
  input  logic [stsm_pkg::IDX_W-1:0] in_high_index,
  input  logic [stsm_pkg::VAL_W-1:0] in_operand_value,
  output logic                       out_valid,
  output logic [stsm_pkg::SUM_W-1:0] out_range_sum
);
  import stsm_pkg::*;

  localparam int LW      = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int AW      = LW + 1;
  localparam int P_NODES = 1 << LW;
  localparam logic [31:0] LAST = 32'(NUM_ELEMENTS - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_Q     = 4'd2;
  localparam logic [3:0] S_QA    = 4'd3;
  localparam logic [3:0] S_MROOT = 4'd4;
  localparam logic [3:0] S_ML    = 4'd5;
  localparam logic [3:0] S_MLW   = 4'd6;
  localparam logic [3:0] S_MDIV  = 4'd7;
  localparam logic [3:0] S_MNX   = 4'd8;
  localparam logic [3:0] S_RL    = 4'd9;
  localparam logic [3:0] S_RR    = 4'd10;
  localparam logic [3:0] S_RW    = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW:0]      ql_r, ql_nxt, qr_r, qr_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [AW-1:0]    idx_r, idx_nxt, end_r, end_nxt;
  logic [AW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, p_r, p_nxt;
  logic [VAL_W-1:0] dv_r, dv_nxt;
  node_t            left_r, left_nxt;
  logic             ov_r, ov_nxt;
  logic [SUM_W-1:0] osum_r, osum_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  node_t            wdata, rdata;
  logic             div_go, div_done;
  logic [VAL_W-1:0] div_rem;

  logic [31:0]      a_ext, b_ext, b_clamp;
  logic             a_in, ok;
  logic [AW-1:0]    leaf_a, leaf_b;

  assign a_ext   = 32'(in_low_index);
  assign b_ext   = 32'(in_high_index);
  assign b_clamp = (b_ext > LAST) ? LAST : b_ext;
  assign a_in    = (a_ext <= LAST);
  assign ok      = a_in && (a_ext <= b_clamp);
  assign leaf_a  = AW'(P_NODES) + AW'(a_ext);
  assign leaf_b  = AW'(P_NODES) + AW'(b_clamp);

  stsm_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  stsm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (rdata.maxv),
    .divisor   (dv_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    ql_nxt    = ql_r;
    qr_nxt    = qr_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    p_nxt     = p_r;
    dv_nxt    = dv_r;
    left_nxt  = left_r;
    ov_nxt    = 1'b0;
    osum_nxt  = osum_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;
    div_go    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_ASSIGN: begin
              if (a_in) begin
                we         = 1'b1;
                waddr      = leaf_a;
                wdata.sum  = SUM_W'(in_operand_value);
                wdata.maxv = in_operand_value;
                lo_nxt     = leaf_a >> 1;
                hi_nxt     = leaf_a >> 1;
                p_nxt      = leaf_a >> 1;
                state_nxt  = S_RL;
              end
            end
            CMD_QUERY: begin
              acc_nxt = '0;
              if (ok) begin
                ql_nxt    = {1'b0, leaf_a};
                qr_nxt    = {1'b0, leaf_b} + 1'b1;
                state_nxt = S_Q;
              end else begin
                ov_nxt   = 1'b1;
                osum_nxt = '0;
              end
            end
            CMD_MODULO: begin
              if (ok && in_operand_value != '0) begin
                raddr     = AW'(1);
                dv_nxt    = in_operand_value;
                idx_nxt   = leaf_a;
                end_nxt   = leaf_b;
                lo_nxt    = leaf_a >> 1;
                hi_nxt    = leaf_b >> 1;
                state_nxt = S_MROOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_Q: begin
        if (ql_r < qr_r) begin
          if (ql_r[0]) begin
            raddr     = ql_r[AW-1:0];
            ql_nxt    = ql_r + 1'b1;
            state_nxt = S_QA;
          end else if (qr_r[0]) begin
            raddr     = AW'(qr_r - 1'b1);
            qr_nxt    = qr_r - 1'b1;
            state_nxt = S_QA;
          end else begin
            ql_nxt = ql_r >> 1;
            qr_nxt = qr_r >> 1;
          end
        end else begin
          ov_nxt    = 1'b1;
          osum_nxt  = acc_r;
          state_nxt = S_IDLE;
        end
      end
      S_QA: begin
        acc_nxt   = acc_r + rdata.sum;
        state_nxt = S_Q;
      end
      S_MROOT: begin
        if (rdata.maxv < dv_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ML;
        end
      end
      S_ML: begin
        raddr     = idx_r;
        state_nxt = S_MLW;
      end
      S_MLW: begin
        if (rdata.maxv >= dv_r) begin
          div_go    = 1'b1;
          state_nxt = S_MDIV;
        end else begin
          state_nxt = S_MNX;
        end
      end
      S_MDIV: begin
        if (div_done) begin
          we         = 1'b1;
          waddr      = idx_r;
          wdata.sum  = SUM_W'(div_rem);
          wdata.maxv = div_rem;
          state_nxt  = S_MNX;
        end
      end
      S_MNX: begin
        if (idx_r == end_r) begin
          p_nxt     = lo_r;
          state_nxt = S_RL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ML;
        end
      end
      S_RL: begin
        raddr     = {p_r[AW-2:0], 1'b0};
        state_nxt = S_RR;
      end
      S_RR: begin
        raddr     = {p_r[AW-2:0], 1'b1};
        left_nxt  = rdata;
        state_nxt = S_RW;
      end
      S_RW: begin
        we         = 1'b1;
        waddr      = p_r;
        wdata.sum  = left_r.sum + rdata.sum;
        wdata.maxv = (left_r.maxv > rdata.maxv) ? left_r.maxv : rdata.maxv;
        if (p_r == hi_r) begin
          if (lo_r == AW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            lo_nxt    = lo_r >> 1;
            hi_nxt    = hi_r >> 1;
            p_nxt     = lo_r >> 1;
            state_nxt = S_RL;
          end
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_RL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    ql_r   <= ql_nxt;
    qr_r   <= qr_nxt;
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    p_r    <= p_nxt;
    dv_r   <= dv_nxt;
    left_r <= left_nxt;
    osum_r <= osum_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_range_sum = osum_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !(start && in_command == CMD_QUERY)) |=> !out_valid)
    else $error("result strobe repeated without a new query");

  a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_QUERY) |=> (busy || out_valid))
    else $error("query neither started nor answered");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block idle right after reset");

  a_no_result_when_busy_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command != CMD_QUERY) |=> !out_valid)
    else $error("result produced for a command without one");
endmodule

// File: dv/segment_tree_sum_max_range_modulo_test.sv
// Testbench for segment_tree_sum_max_range_modulo: directed and random commands,
// each range sum result checked against a flat element array kept here.
// Depends on stsm_pkg and the RTL of the block only.
module segment_tree_sum_max_range_modulo_test;
  import stsm_pkg::*;

  localparam int NUM_ELEM = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_command = '0;
  logic [IDX_W-1:0] in_low_index = '0;
  logic [IDX_W-1:0] in_high_index = '0;
  logic [VAL_W-1:0] in_operand_value = '0;
  logic out_valid;
  logic [SUM_W-1:0] out_range_sum;

  logic [VAL_W-1:0] elements [0:NUM_ELEM-1];
  logic [SUM_W-1:0] pending_sums [$];
  logic [SUM_W-1:0] expected_sum;
  int errors = 0;
  longint cycles = 0;

  segment_tree_sum_max_range_modulo u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_low_index(in_low_index),
    .in_high_index(in_high_index), .in_operand_value(in_operand_value),
    .out_valid(out_valid), .out_range_sum(out_range_sum)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $error("range_sum expected none actual %0d", out_range_sum);
        errors++;
      end else begin
        expected_sum = pending_sums.pop_front();
        if (out_range_sum !== expected_sum) begin
          $error("range_sum expected %0d actual %0d", expected_sum, out_range_sum);
          errors++;
        end
      end
    end
  end

  // Updates the element array for one accepted command and queues any sum.
  task automatic predict_command(input logic [CMD_W-1:0] cmd, input int lo, input int hi,
                                 input logic [VAL_W-1:0] val);
    logic [63:0] acc;
    int top;
    acc = 0;
    top = (hi > NUM_ELEM - 1) ? NUM_ELEM - 1 : hi;
    case (cmd)
      CMD_ASSIGN: begin
        if (lo < NUM_ELEM) elements[lo] = val;
      end
      CMD_QUERY: begin
        if (lo < NUM_ELEM && lo <= top)
          for (int i = lo; i <= top; i++) acc += elements[i];
        pending_sums.push_back(acc > SUM_SAT ? SUM_SAT : acc[SUM_W-1:0]);
      end
      CMD_MODULO: begin
        if (lo < NUM_ELEM && lo <= top && val != 0)
          for (int i = lo; i <= top; i++) elements[i] = elements[i] % val;
      end
      default: ;
    endcase
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input int lo, input int hi,
                              input logic [VAL_W-1:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_low_index <= lo[IDX_W-1:0];
    in_high_index <= hi[IDX_W-1:0];
    in_operand_value <= val;
    do @(posedge clk); while (busy);
    predict_command(cmd, int'(lo[IDX_W-1:0]), int'(hi[IDX_W-1:0]), val);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_cleared_store();
    send_command(CMD_QUERY, 0, NUM_ELEM - 1, 0);
    send_command(CMD_QUERY, 511, 512, 0);
  endtask

  task automatic test_assign_extremes();
    send_command(CMD_ASSIGN, 0, 0, 32'hFFFF_FFFF);
    send_command(CMD_ASSIGN, NUM_ELEM - 1, 0, 32'hFFFF_FFFF);
    send_command(CMD_ASSIGN, 512, 1023, 32'h8000_0001);
    send_command(CMD_ASSIGN, 3, 0, 32'd1);
    send_command(CMD_QUERY, 0, NUM_ELEM - 1, 0);
    send_command(CMD_QUERY, 0, 0, 0);
    send_command(CMD_QUERY, NUM_ELEM - 1, NUM_ELEM - 1, 0);
  endtask

  task automatic test_special_cases();
    send_command(CMD_QUERY, 600, 5, 0);
    send_command(CMD_MODULO, 900, 2, 7);
    send_command(CMD_MODULO, 0, 15, 0);
    send_command(CMD_UNUSED, 0, 1023, 32'h1234_5678);
    send_command(CMD_MODULO, 0, 3, 32'hFFFF_FFFF);
    send_command(CMD_MODULO, 0, 7, 32'd10);
    send_command(CMD_MODULO, 1020, 1023, 32'd1);
    send_command(CMD_MODULO, 500, 515, 32'd3);
    send_command(CMD_QUERY, 0, NUM_ELEM - 1, 0);
    send_command(CMD_QUERY, 0, 7, 0);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    int lo;
    int hi;
    logic [VAL_W-1:0] val;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      lo = $urandom_range(0, NUM_ELEM - 1);
      hi = $urandom_range(0, NUM_ELEM - 1);
      val = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1000) : $urandom;
      if (pick < 35) begin
        send_command(CMD_ASSIGN, lo, hi, val);
      end else if (pick < 70) begin
        if ($urandom_range(0, 1) == 0 && lo > hi) send_command(CMD_QUERY, hi, lo, val);
        else send_command(CMD_QUERY, lo, hi, val);
      end else if (pick < 95) begin
        if ($urandom_range(0, 99) != 0) begin
          hi = lo + $urandom_range(0, 15);
          if (hi > NUM_ELEM - 1) hi = NUM_ELEM - 1;
          if ($urandom_range(0, 19) == 0) hi = $urandom_range(0, NUM_ELEM - 1);
          if (hi - lo > 15) hi = lo - 1;
        end
        case ($urandom_range(0, 3))
          0: val = $urandom_range(1, 16);
          1: val = $urandom_range(0, 1000);
          default: val = $urandom;
        endcase
        send_command(CMD_MODULO, lo, hi, val);
      end else begin
        send_command(CMD_UNUSED, lo, hi, val);
      end
    end
  endtask

  task automatic test_full_range_modulo();
    send_command(CMD_MODULO, 0, NUM_ELEM - 1, 32'hFFFF_FFFF);
    send_command(CMD_MODULO, 0, NUM_ELEM - 1, 32'd1000);
    send_command(CMD_QUERY, 0, NUM_ELEM - 1, 0);
  endtask

  initial begin
    for (int i = 0; i < NUM_ELEM; i++) elements[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_cleared_store();
    test_assign_extremes();
    test_special_cases();
    wait_for_results();
    test_random_traffic(500);
    wait_for_results();
    test_full_range_modulo();
    test_random_traffic(520);
    wait_for_results();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
